### hw/rtl/fsso_pkg.sv
`default_nettype none

package fsso_pkg;

  // Request word
  typedef struct packed {
    logic [15:0] ready_users;
    logic        plan_valid;
    logic [16:0] tx_probability;
    logic [15:0] base_window;
    logic [31:0] backlog_bits;
    logic [15:0] bits_per_slot;
    logic [7:0]  frame_slots;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [7:0] online_slots;
    logic [7:0] yellow_slots;
    logic [7:0] ra_slots;
  } out_word_t;

  // Configuration register file contents
  typedef struct packed {
    logic [31:0] base_delay;
    logic [15:0] delay_weight;
    logic [7:0]  ra_min_slots;
    logic [7:0]  ra_max_slots;
    logic [7:0]  reserved_slots;
  } cfg_t;

  // Register indexes
  localparam logic [2:0] REG_BASE_DELAY     = 3'd0;
  localparam logic [2:0] REG_DELAY_WEIGHT   = 3'd1;
  localparam logic [2:0] REG_RA_MIN_SLOTS   = 3'd2;
  localparam logic [2:0] REG_RA_MAX_SLOTS   = 3'd3;
  localparam logic [2:0] REG_RESERVED_SLOTS = 3'd4;

  // Divider operand selection
  typedef enum logic [2:0] {
    DSEL_A,   // aggressiveness
    DSEL_Q,   // backlog in slots
    DSEL_G,   // exponent argument
    DSEL_E,   // exp / a
    DSEL_D    // scheduled delay
  } div_sel_e;

  // Controller to datapath
  typedef struct packed {
    logic     load;
    logic     div_start;
    logic     div_cap;
    div_sel_e div_sel;
    logic     mul_na;
    logic     exp_frac;
    logic     exp_int;
    logic     weight;
    logic     cost;
    logic     out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_done;
    logic r_in_range;
    logic out_busy;
  } status_t;

  // e^i, i = 0..11, Q16
  localparam logic [11:0][31:0] EXP_INT_Q16 = {
    32'd3923911752, 32'd1443526462, 32'd531043708, 32'd195360063,
    32'd71868951,   32'd26439109,   32'd9726405,   32'd3578144,
    32'd1316326,    32'd484249,     32'd178145,    32'd65536
  };

  // e^(k/8), k = 0..8, Q30
  localparam logic [8:0][31:0] EXP_FRAC_Q30 = {
    32'd2918732888, 32'd2575772732, 32'd2273111460, 32'd2006013822,
    32'd1770300985, 32'd1562285136, 32'd1378711793, 32'd1216708891,
    32'd1073741824
  };

endpackage

`default_nettype wire

### hw/rtl/fsso_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle
module fsso_div #(
  parameter int NW = 48,
  parameter int DW = 33
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  output logic               done_o,
  output logic [NW-1:0]      quo_o
);

  localparam int CNTW = $clog2(NW + 1);

  logic [NW-1:0]   quo_q, quo_d;
  logic [DW-1:0]   rem_q, rem_d;
  logic [DW-1:0]   den_q;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [DW:0]     shifted;
  logic [DW:0]     trial;
  logic            fits;

  // One trial subtraction
  always_comb begin
    shifted = {rem_q, quo_q[NW-1]};
    trial   = shifted - {1'b0, den_q};
    fits    = shifted >= {1'b0, den_q};
  end

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      cnt_d  = CNTW'(NW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[NW-2:0], fits};
      rem_d = fits ? trial[DW-1:0] : shifted[DW-1:0];
      cnt_d = cnt_q - CNTW'(1);
      if (cnt_q == CNTW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

### hw/rtl/fsso_dp.sv
`default_nettype none

module fsso_dp #(
  parameter int FRACTION_BITS = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire fsso_pkg::cfg_t    cfg_i,
  input  wire fsso_pkg::in_word_t in_word_i,
  input  wire fsso_pkg::cmd_t    cmd_i,
  output fsso_pkg::status_t      status_o,
  input  wire logic              out_ready_i,
  output logic                   out_valid_o,
  output fsso_pkg::out_word_t    out_word_o
);

  import fsso_pkg::*;

  localparam int F    = FRACTION_BITS;
  localparam int CW   = F + 16;            // saturation width
  localparam int AW   = F + 2;             // aggressiveness width
  localparam int QW   = 32 + F;            // backlog in slots
  localparam int GW   = F + 10;            // exponent argument
  localparam int EW   = 2 * F + 16;        // exp shifted up
  localparam int NW   = (QW > EW) ? QW : EW;
  localparam int DW   = 33;
  localparam int STEP = F - 3;
  localparam logic [CW-1:0] CAP = '1;
  localparam logic [GW-1:0] EXP_LIMIT = GW'(12) << F;

  in_word_t       in_q;
  logic [AW-1:0]  a_q;
  logic [QW-1:0]  q_q;
  logic [GW-1:0]  na_q;
  logic [GW-1:0]  g_q;
  logic [31:0]    fv_q;
  logic [CW-1:0]  e_q;
  logic [CW-1:0]  dra_q;
  logic [CW-1:0]  dda_q;
  logic [CW-1:0]  wda_q;
  logic [CW-1:0]  best_cost_q;
  logic [7:0]     best_r_q;
  logic [8:0]     r_q;
  logic           found_q;
  logic           out_valid_q;
  out_word_t      out_q;

  // Request operands
  logic [16:0]    ptx;
  logic [16:0]    win;
  logic [15:0]    bps;
  logic [7:0]     avail;
  logic [7:0]     hi;
  logic [7:0]     rdiv;
  logic [7:0]     ds;
  logic [QW-1:0]  d0_full;
  logic [CW-1:0]  d0;

  always_comb begin
    if (!in_q.plan_valid) begin
      ptx = 17'd32768;
      win = 17'd1;
    end else begin
      ptx = (in_q.tx_probability > 17'd65536) ? 17'd65536 : in_q.tx_probability;
      win = {1'b0, in_q.base_window};
    end
    bps     = (in_q.bits_per_slot == 16'd0) ? 16'd1 : in_q.bits_per_slot;
    avail   = (in_q.frame_slots > cfg_i.reserved_slots) ?
              in_q.frame_slots - cfg_i.reserved_slots : 8'd0;
    hi      = (cfg_i.ra_max_slots < avail) ? cfg_i.ra_max_slots : avail;
    rdiv    = (r_q[7:0] > 8'd1) ? r_q[7:0] : 8'd1;
    ds      = avail - r_q[7:0];
    d0_full = ({{F{1'b0}}, cfg_i.base_delay} << F) >> 16;
    d0      = (d0_full > QW'(CAP)) ? CAP : d0_full[CW-1:0];
  end

  // Divider operand mux
  logic [NW-1:0] div_num;
  logic [DW-1:0] div_den;
  logic          div_done;
  logic [NW-1:0] div_quo;

  always_comb begin
    div_num = '0;
    div_den = DW'(1);
    case (cmd_i.div_sel)
      DSEL_A: begin
        div_num = NW'({ptx, 1'b0}) << F;
        div_den = {16'd0, win + 17'd1} << 16;
      end
      DSEL_Q: begin
        div_num = NW'({in_q.backlog_bits, {F{1'b0}}});
        div_den = DW'(bps);
      end
      DSEL_G: begin
        div_num = NW'(na_q);
        div_den = DW'(rdiv);
      end
      DSEL_E: begin
        div_num = NW'({e_q, {F{1'b0}}});
        div_den = DW'(a_q);
      end
      DSEL_D: begin
        div_num = NW'(q_q);
        div_den = (ds > 8'd1) ? DW'(ds) : DW'(1);
      end
      default: begin
        div_num = '0;
        div_den = DW'(1);
      end
    endcase
  end

  fsso_div #(
    .NW (NW),
    .DW (DW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Saturated quotient and random-access delay
  logic [CW-1:0] quo_sat;
  logic [CW:0]   dra_sum;
  always_comb begin
    quo_sat = (div_quo > NW'(CAP)) ? CAP : div_quo[CW-1:0];
    dra_sum = {1'b0, d0} + {1'b0, quo_sat};
  end

  // exp: interpolate fraction table, then scale by integer table
  logic [2:0]          fj;
  logic [3:0]          fj1;
  logic [STEP-1:0]     frem;
  logic [31:0]         t0, t1, tdiff;
  logic [32+STEP-1:0]  tprod;
  logic [31:0]         fv_d;
  logic                big;
  logic [3:0]          ei;
  logic [63:0]         eprod;
  logic [63:0]         eshift;
  logic [CW-1:0]       e_d;

  always_comb begin
    fj     = g_q[F-1 -: 3];
    fj1    = {1'b0, fj} + 4'd1;
    frem   = g_q[STEP-1:0];
    t0     = EXP_FRAC_Q30[fj];
    t1     = EXP_FRAC_Q30[fj1];
    tdiff  = t1 - t0;
    tprod  = (32+STEP)'(tdiff) * (32+STEP)'(frem);
    fv_d   = t0 + 32'(tprod >> STEP);
    big    = g_q >= EXP_LIMIT;
    ei     = big ? 4'd0 : g_q[F+3:F];
    eprod  = 64'(EXP_INT_Q16[ei]) * 64'(fv_q);
    eshift = eprod >> (46 - F);
    if (big || eshift > 64'(CAP)) begin
      e_d = CAP;
    end else begin
      e_d = eshift[CW-1:0];
    end
  end

  // Weighted scheduled delay and cost
  logic [CW+15:0] wprod;
  logic [CW+7:0]  wshift;
  logic [CW-1:0]  cost;
  always_comb begin
    wprod  = (CW+16)'(dda_q) * (CW+16)'(cfg_i.delay_weight);
    wshift = wprod[CW+15:8];
    cost   = (dra_q > wda_q) ? dra_q - wda_q : wda_q - dra_q;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.load) begin
        found_q <= 1'b0;
      end else if (cmd_i.cost) begin
        found_q <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_q     <= in_word_i;
      r_q      <= {1'b0, cfg_i.ra_min_slots};
      best_r_q <= cfg_i.ra_min_slots;
    end
    if (cmd_i.div_cap) begin
      case (cmd_i.div_sel)
        DSEL_A: a_q <= (div_quo == '0) ? AW'(1) : div_quo[AW-1:0];
        DSEL_Q: q_q <= div_quo[QW-1:0];
        DSEL_G: g_q <= div_quo[GW-1:0];
        DSEL_E: dra_q <= dra_sum[CW] ? CAP : dra_sum[CW-1:0];
        DSEL_D: dda_q <= quo_sat;
        default: ;
      endcase
    end
    if (cmd_i.mul_na) begin
      na_q <= GW'((({{(F+2){1'b0}}, in_q.ready_users, {(F-8){1'b0}}}) *
                   (2*F+10)'(a_q)) >> F);
    end
    if (cmd_i.exp_frac) begin
      fv_q <= fv_d;
    end
    if (cmd_i.exp_int) begin
      e_q <= e_d;
    end
    if (cmd_i.weight) begin
      wda_q <= (wshift > (CW+8)'(CAP)) ? CAP : wshift[CW-1:0];
    end
    if (cmd_i.cost) begin
      if (!found_q || cost < best_cost_q) begin
        best_cost_q <= cost;
        best_r_q    <= r_q[7:0];
      end
      r_q <= r_q + 9'd1;
    end
    if (cmd_i.out_load) begin
      out_q.online_slots <= (avail > best_r_q) ? avail - best_r_q : 8'd0;
      out_q.yellow_slots <= cfg_i.reserved_slots;
      out_q.ra_slots     <= best_r_q;
    end
  end

  assign status_o.div_done   = div_done;
  assign status_o.r_in_range = r_q <= {1'b0, hi};
  assign status_o.out_busy   = out_valid_q && !out_ready_i;
  assign out_valid_o         = out_valid_q;
  assign out_word_o          = out_q;

endmodule

`default_nettype wire

### hw/rtl/fsso_ctrl.sv
`default_nettype none

module fsso_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire fsso_pkg::status_t status_i,
  output fsso_pkg::cmd_t         cmd_o
);

  import fsso_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_DA   = 5'd1;
  localparam logic [4:0] S_WA   = 5'd2;
  localparam logic [4:0] S_NA   = 5'd3;
  localparam logic [4:0] S_DQ   = 5'd4;
  localparam logic [4:0] S_WQ   = 5'd5;
  localparam logic [4:0] S_CHK  = 5'd6;
  localparam logic [4:0] S_DG   = 5'd7;
  localparam logic [4:0] S_WG   = 5'd8;
  localparam logic [4:0] S_EF   = 5'd9;
  localparam logic [4:0] S_EI   = 5'd10;
  localparam logic [4:0] S_DE   = 5'd11;
  localparam logic [4:0] S_WE   = 5'd12;
  localparam logic [4:0] S_DD   = 5'd13;
  localparam logic [4:0] S_WD   = 5'd14;
  localparam logic [4:0] S_WT   = 5'd15;
  localparam logic [4:0] S_CT   = 5'd16;
  localparam logic [4:0] S_OUT  = 5'd17;

  logic [4:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DA;
        end
      end
      S_DA: begin
        cmd_o.div_sel   = DSEL_A;
        cmd_o.div_start = 1'b1;
        state_d         = S_WA;
      end
      S_WA: begin
        cmd_o.div_sel = DSEL_A;
        cmd_o.div_cap = status_i.div_done;
        if (status_i.div_done) state_d = S_NA;
      end
      S_NA: begin
        cmd_o.mul_na = 1'b1;
        state_d      = S_DQ;
      end
      S_DQ: begin
        cmd_o.div_sel   = DSEL_Q;
        cmd_o.div_start = 1'b1;
        state_d         = S_WQ;
      end
      S_WQ: begin
        cmd_o.div_sel = DSEL_Q;
        cmd_o.div_cap = status_i.div_done;
        if (status_i.div_done) state_d = S_CHK;
      end
      // next slot count or finish
      S_CHK: begin
        state_d = status_i.r_in_range ? S_DG : S_OUT;
      end
      S_DG: begin
        cmd_o.div_sel   = DSEL_G;
        cmd_o.div_start = 1'b1;
        state_d         = S_WG;
      end
      S_WG: begin
        cmd_o.div_sel = DSEL_G;
        cmd_o.div_cap = status_i.div_done;
        if (status_i.div_done) state_d = S_EF;
      end
      S_EF: begin
        cmd_o.exp_frac = 1'b1;
        state_d        = S_EI;
      end
      S_EI: begin
        cmd_o.exp_int = 1'b1;
        state_d       = S_DE;
      end
      S_DE: begin
        cmd_o.div_sel   = DSEL_E;
        cmd_o.div_start = 1'b1;
        state_d         = S_WE;
      end
      S_WE: begin
        cmd_o.div_sel = DSEL_E;
        cmd_o.div_cap = status_i.div_done;
        if (status_i.div_done) state_d = S_DD;
      end
      S_DD: begin
        cmd_o.div_sel   = DSEL_D;
        cmd_o.div_start = 1'b1;
        state_d         = S_WD;
      end
      S_WD: begin
        cmd_o.div_sel = DSEL_D;
        cmd_o.div_cap = status_i.div_done;
        if (status_i.div_done) state_d = S_WT;
      end
      S_WT: begin
        cmd_o.weight = 1'b1;
        state_d      = S_CT;
      end
      S_CT: begin
        cmd_o.cost = 1'b1;
        state_d    = S_CHK;
      end
      // hand result to the output register once it is free
      S_OUT: begin
        if (!status_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/frame_slot_split_optimizer_core.sv
`default_nettype none

// Channel  Handshake                       Word
// in       in_valid_i / in_ready_o         in_word_i  (fsso_pkg::in_word_t)
// out      out_valid_o / out_ready_i       out_word_o (fsso_pkg::out_word_t)
// cfg      psel/penable/pwrite, pready=1   paddr, pwdata, prdata
//
// One request at a time. All divisions share one divider that yields one
// quotient bit per cycle; its numerator is NW = max(32+F, 2F+16) bits
// wide (48 at F=16).
// in_ready_o is high only while idle; the result sits in an output register,
// so a new request is taken while the previous word waits downstream.
// Reset is asynchronous and covers the config and control registers only.
module frame_slot_split_optimizer_core #(
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire fsso_pkg::in_word_t  in_word_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output fsso_pkg::out_word_t      out_word_o,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [4:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  import fsso_pkg::*;

  cfg_t    cfg_q;
  cmd_t    cmd;
  status_t status;
  logic    wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_delay     <= 32'd0;
      cfg_q.delay_weight   <= 16'd256;
      cfg_q.ra_min_slots   <= 8'd1;
      cfg_q.ra_max_slots   <= 8'd16;
      cfg_q.reserved_slots <= 8'd0;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        REG_BASE_DELAY:     cfg_q.base_delay     <= pwdata;
        REG_DELAY_WEIGHT:   cfg_q.delay_weight   <= pwdata[15:0];
        REG_RA_MIN_SLOTS:   cfg_q.ra_min_slots   <= pwdata[7:0];
        REG_RA_MAX_SLOTS:   cfg_q.ra_max_slots   <= pwdata[7:0];
        REG_RESERVED_SLOTS: cfg_q.reserved_slots <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (paddr[4:2])
      REG_BASE_DELAY:     prdata = cfg_q.base_delay;
      REG_DELAY_WEIGHT:   prdata = {16'd0, cfg_q.delay_weight};
      REG_RA_MIN_SLOTS:   prdata = {24'd0, cfg_q.ra_min_slots};
      REG_RA_MAX_SLOTS:   prdata = {24'd0, cfg_q.ra_max_slots};
      REG_RESERVED_SLOTS: prdata = {24'd0, cfg_q.reserved_slots};
      default:            prdata = 32'd0;
    endcase
  end

  fsso_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  fsso_dp #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire
